>>> hdl/rhwf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhwf_pkg
// Types, codes and sizes shared by the right-hand wall follower.
// ----------------------------------------------------------------------------
package rhwf_pkg;

	localparam int MAX_WIDTH   = 64;
	localparam int MAX_HEIGHT  = 64;
	localparam int COORD_W     = 6;
	localparam int SIZE_W      = 7;
	localparam int WALL_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int SEEN_ROW_W  = MAX_WIDTH * 4;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 7;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_X     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_START_Y     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_END_X       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_END_Y       = 3'd5;

	// request codes
	localparam logic [1:0] REQ_LOAD    = 2'd0;
	localparam logic [1:0] REQ_STEP    = 2'd1;
	localparam logic [1:0] REQ_RESTART = 2'd2;

	// headings
	localparam logic [1:0] HEAD_N = 2'd0;
	localparam logic [1:0] HEAD_E = 2'd1;
	localparam logic [1:0] HEAD_S = 2'd2;
	localparam logic [1:0] HEAD_W = 2'd3;

	// result status codes
	localparam logic [2:0] STAT_ACCEPTED = 3'd0;
	localparam logic [2:0] STAT_MOVED    = 3'd1;
	localparam logic [2:0] STAT_GOAL     = 3'd2;
	localparam logic [2:0] STAT_LOOP     = 3'd3;
	localparam logic [2:0] STAT_WALLED   = 3'd4;
	localparam logic [2:0] STAT_FINISHED = 3'd5;

	// right, straight, left, back as offsets added to the heading
	localparam logic [1:0] TURN_ORDER [4] = '{2'd1, 2'd0, 2'd3, 2'd2};

	typedef struct packed {
		logic [1:0]         req_type;
		logic [COORD_W-1:0] cell_x;
		logic [COORD_W-1:0] cell_y;
		logic               wall_bit;
	} req_t;

	typedef struct packed {
		logic [COORD_W-1:0] walker_x;
		logic [COORD_W-1:0] walker_y;
		logic [1:0]         walker_heading;
		logic [2:0]         status;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEEN,
		ST_PROBE_ISSUE,
		ST_PROBE_WAIT,
		ST_EMIT
	} state_t;

endpackage

>>> hdl/right_hand_wall_follower.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// right_hand_wall_follower
// Right-hand wall follower over a grid maze held in an on-chip wall bitmap.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+------------------
//  req      | in        | req_valid / req_stall     | req_t
//  rsp      | out       | rsp_valid / rsp_stall     | rsp_t
//  cfg      | in        | cfg_write                 | cfg_index, cfg_data
//
//  load, restart and steps that end at once (finished, goal) go straight from
//  acceptance to the result state; a full step first checks the seen store,
//  then tries one direction at a time through the single wall-map read port
//  that the shared neighbour unit probes.
//  one item is in work at a time; req_stall is high until its result is
//  registered, and a result waiting on rsp_stall holds back the next one.
//  reset and restart clear the seen store at once through per-row flags.
// ----------------------------------------------------------------------------
module right_hand_wall_follower import rhwf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output rsp_t                  rsp,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	state_t state_q, state_nxt;

	logic [SIZE_W-1:0]  grid_width_q, grid_height_q;
	logic [COORD_W-1:0] start_x_q, start_y_q, end_x_q, end_y_q;
	logic [COORD_W-1:0] pos_x_q, pos_y_q;
	logic [1:0]         heading_q;
	logic               finished_q;
	logic [MAX_HEIGHT-1:0] row_valid_q;
	logic [1:0]         k_q;
	logic [COORD_W-1:0] cand_x_q, cand_y_q;
	logic [1:0]         cand_h_q;
	logic [2:0]         status_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic accept, out_free, at_end, cand_at_end;
	logic [1:0]        nb_h;
	logic [SIZE_W-1:0] nb_x, nb_y;
	logic              on_grid;
	logic              wall_rdata;
	logic [SEEN_ROW_W-1:0] seen_rdata, seen_row, seen_wdata;
	logic [$clog2(SEEN_ROW_W)-1:0] seen_bit;
	logic seen_hit, seen_we;

	// sequencer controls
	logic       status_ld;
	logic [2:0] status_nxt;
	logic       k_clr, k_inc, cand_ld, do_move, emit;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign at_end    = (pos_x_q == end_x_q) && (pos_y_q == end_y_q);
	assign cand_at_end = (cand_x_q == end_x_q) && (cand_y_q == end_y_q);

	// shared neighbour unit: heading after the turn and the cell it faces
	always_comb begin
		nb_h = heading_q + TURN_ORDER[k_q];
		nb_x = {1'b0, pos_x_q};
		nb_y = {1'b0, pos_y_q};
		unique case (nb_h)
			HEAD_N:  nb_y = {1'b0, pos_y_q} - SIZE_W'(1);
			HEAD_E:  nb_x = {1'b0, pos_x_q} + SIZE_W'(1);
			HEAD_S:  nb_y = {1'b0, pos_y_q} + SIZE_W'(1);
			HEAD_W:  nb_x = {1'b0, pos_x_q} - SIZE_W'(1);
			default: nb_x = {1'b0, pos_x_q};
		endcase
	end

	// a step below zero wraps to a value with the top bit set
	assign on_grid = !nb_x[SIZE_W-1] && !nb_y[SIZE_W-1]
		&& (nb_x < grid_width_q) && (nb_y < grid_height_q);

	rhwf_ram #(.WIDTH(1), .DEPTH(WALL_DEPTH)) u_wall_ram (
		.clk   (clk),
		.we    (accept && (req.req_type == REQ_LOAD)),
		.waddr ({req.cell_y, req.cell_x}),
		.wdata (req.wall_bit),
		.raddr ({nb_y[COORD_W-1:0], nb_x[COORD_W-1:0]}),
		.rdata (wall_rdata)
	);

	// seen store: one row per grid row, one bit per column and heading
	assign seen_row   = row_valid_q[pos_y_q] ? seen_rdata : '0;
	assign seen_bit   = {pos_x_q, heading_q};
	assign seen_hit   = seen_row[seen_bit];
	assign seen_wdata = seen_row | (SEEN_ROW_W'(1) << seen_bit);

	rhwf_ram #(.WIDTH(SEEN_ROW_W), .DEPTH(MAX_HEIGHT)) u_seen_ram (
		.clk   (clk),
		.we    (seen_we),
		.waddr (pos_y_q),
		.wdata (seen_wdata),
		.raddr (pos_y_q),
		.rdata (seen_rdata)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.req_type == REQ_STEP && !finished_q && !at_end)
						state_nxt = ST_SEEN;
					else
						state_nxt = ST_EMIT;
				end
			end
			ST_SEEN: begin
				state_nxt = seen_hit ? ST_EMIT : ST_PROBE_ISSUE;
			end
			ST_PROBE_ISSUE: begin
				if (on_grid)
					state_nxt = ST_PROBE_WAIT;
				else if (k_q == 2'd3)
					state_nxt = ST_EMIT;
			end
			ST_PROBE_WAIT: begin
				if (!wall_rdata || k_q == 2'd3)
					state_nxt = ST_EMIT;
				else
					state_nxt = ST_PROBE_ISSUE;
			end
			ST_EMIT: begin
				if (out_free)
					state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		status_ld  = 1'b0;
		status_nxt = STAT_ACCEPTED;
		k_clr      = 1'b0;
		k_inc      = 1'b0;
		cand_ld    = 1'b0;
		do_move    = 1'b0;
		seen_we    = 1'b0;
		emit       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					status_ld = 1'b1;
					if (req.req_type == REQ_STEP) begin
						if (finished_q)
							status_nxt = STAT_FINISHED;
						else if (at_end)
							status_nxt = STAT_GOAL;
					end
				end
			end
			ST_SEEN: begin
				k_clr = 1'b1;
				if (seen_hit) begin
					status_ld  = 1'b1;
					status_nxt = STAT_LOOP;
				end else begin
					seen_we = 1'b1;
				end
			end
			ST_PROBE_ISSUE: begin
				cand_ld = 1'b1;
				if (!on_grid) begin
					k_inc = 1'b1;
					if (k_q == 2'd3) begin
						status_ld  = 1'b1;
						status_nxt = STAT_WALLED;
					end
				end
			end
			ST_PROBE_WAIT: begin
				if (!wall_rdata) begin
					do_move    = 1'b1;
					status_ld  = 1'b1;
					status_nxt = cand_at_end ? STAT_GOAL : STAT_MOVED;
				end else begin
					k_inc = 1'b1;
					if (k_q == 2'd3) begin
						status_ld  = 1'b1;
						status_nxt = STAT_WALLED;
					end
				end
			end
			ST_EMIT: begin
				emit = out_free;
			end
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			grid_width_q  <= SIZE_W'(MAX_WIDTH);
			grid_height_q <= SIZE_W'(MAX_HEIGHT);
			start_x_q     <= '0;
			start_y_q     <= '0;
			end_x_q       <= COORD_W'(MAX_WIDTH - 1);
			end_y_q       <= COORD_W'(MAX_HEIGHT - 1);
			pos_x_q       <= '0;
			pos_y_q       <= '0;
			heading_q     <= HEAD_N;
			finished_q    <= 1'b0;
			row_valid_q   <= '0;
			k_q           <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;

			if (cfg_write) begin
				case (cfg_index)
					CFG_GRID_WIDTH:  grid_width_q  <= cfg_data;
					CFG_GRID_HEIGHT: grid_height_q <= cfg_data;
					CFG_START_X:     start_x_q     <= cfg_data[COORD_W-1:0];
					CFG_START_Y:     start_y_q     <= cfg_data[COORD_W-1:0];
					CFG_END_X:       end_x_q       <= cfg_data[COORD_W-1:0];
					CFG_END_Y:       end_y_q       <= cfg_data[COORD_W-1:0];
					default: ;
				endcase
			end

			if (accept && req.req_type == REQ_RESTART) begin
				pos_x_q     <= start_x_q;
				pos_y_q     <= start_y_q;
				heading_q   <= HEAD_N;
				finished_q  <= 1'b0;
				row_valid_q <= '0;
			end
			if (accept && req.req_type == REQ_STEP && !finished_q && at_end)
				finished_q <= 1'b1;

			if (seen_we)
				row_valid_q[pos_y_q] <= 1'b1;

			if (k_clr)
				k_q <= '0;
			else if (k_inc)
				k_q <= k_q + 2'd1;

			if (do_move) begin
				pos_x_q   <= cand_x_q;
				pos_y_q   <= cand_y_q;
				heading_q <= cand_h_q;
				if (cand_at_end)
					finished_q <= 1'b1;
			end

			if (emit)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cand_ld) begin
			cand_x_q <= nb_x[COORD_W-1:0];
			cand_y_q <= nb_y[COORD_W-1:0];
			cand_h_q <= nb_h;
		end
		if (status_ld)
			status_q <= status_nxt;
		if (emit) begin
			rsp_q.walker_x       <= pos_x_q;
			rsp_q.walker_y       <= pos_y_q;
			rsp_q.walker_heading <= heading_q;
			rsp_q.status         <= status_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// a goal result always leaves the walker marked finished
	a_goal_sets_finished: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && status_q == STAT_GOAL) |-> finished_q)
		else $error("goal reported without finished flag");

	// a wall probe is only awaited after it was issued
	a_probe_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE_WAIT) |-> ($past(state_q) == ST_PROBE_ISSUE))
		else $error("probe wait entered without an issued probe");

	// a loop leaves the walker where it stands
	a_loop_holds_walker: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEEN && seen_hit)
		|=> ($stable(pos_x_q) && $stable(pos_y_q) && $stable(heading_q)))
		else $error("walker changed on a loop");

	// a move lands on the cell that was probed
	a_move_to_candidate: assert property (@(posedge clk) disable iff (!arst_n)
		do_move |=> (pos_x_q == $past(cand_x_q) && pos_y_q == $past(cand_y_q)))
		else $error("walker moved to a cell that was not probed");

endmodule

>>> hdl/rhwf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhwf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rhwf_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> tb/sv/right_hand_wall_follower_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// right_hand_wall_follower_test
// Self-checking bench for the right-hand wall follower. A corner block of the
// wall store is loaded open first, closed off by walls along its far row and
// column, and every walk stays inside loaded cells. A short scripted sequence
// then covers moves, loops, walled-in starts, goal and finished states and
// grid extremes. After that, random mazes are loaded inside the block and
// walked under a range of grid settings. Every result is checked against a
// walk predictor kept inside the bench or a fixed scripted value. The sender
// runs in bursts with gaps and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module right_hand_wall_follower_test;
	import rhwf_pkg::*;

	localparam int RANDOM_ITEMS  = 580;
	localparam int WALK_SPAN     = 12;
	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES  = 16;
	localparam int REPORT_MAX    = 10;

	localparam logic [1:0]           REQ_SPARE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd6;

	typedef enum {ROW_ITEM, ROW_REG} row_kind_t;
	typedef enum {STALL_NONE, STALL_RANDOM, STALL_RUNS, STALL_TOGGLE} stall_mode_t;

	typedef struct {
		row_kind_t             kind;
		req_t                  item;
		bit                    fixed;
		rsp_t                  want;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
	} script_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_stall;
	req_t                  req;
	logic                  rsp_valid;
	logic                  rsp_stall;
	rsp_t                  rsp;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	right_hand_wall_follower dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// walk predictor state
	bit                    maze_wall [WALL_DEPTH];
	bit [WALL_DEPTH*4-1:0] visited;
	int                    grid_cols, grid_rows;
	logic [COORD_W-1:0]    start_col, start_row, goal_col, goal_row;
	logic [COORD_W-1:0]    walker_col, walker_row;
	logic [1:0]            walker_dir;
	bit                    walk_done;

	rsp_t        walk_expect_q [$];
	rsp_t        last_outcome;
	script_row_t script [$];
	int          mismatches;
	int          item_count;
	int          setting_count;
	int          status_tally [8];
	int          burst_left;
	bit          fast_sender;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic rsp_t predict_walk(input req_t r);
		rsp_t       o;
		logic [2:0] st;
		logic [1:0] h;
		int         nx, ny, k;
		st = STAT_ACCEPTED;
		case (r.req_type)
			REQ_LOAD: maze_wall[{r.cell_y, r.cell_x}] = r.wall_bit;
			REQ_RESTART: begin
				visited    = '0;
				walker_col = start_col;
				walker_row = start_row;
				walker_dir = HEAD_N;
				walk_done  = 1'b0;
			end
			REQ_STEP: begin
				if (walk_done) begin
					st = STAT_FINISHED;
				end else if (walker_col == goal_col && walker_row == goal_row) begin
					walk_done = 1'b1;
					st = STAT_GOAL;
				end else if (visited[{walker_row, walker_col, walker_dir}]) begin
					st = STAT_LOOP;
				end else begin
					visited[{walker_row, walker_col, walker_dir}] = 1'b1;
					st = STAT_WALLED;
					// right, straight, left, back; first open neighbour wins
					for (k = 0; k < 4 && st == STAT_WALLED; k++) begin
						h  = walker_dir + TURN_ORDER[k];
						nx = walker_col;
						ny = walker_row;
						case (h)
							HEAD_N: ny--;
							HEAD_E: nx++;
							HEAD_S: ny++;
							HEAD_W: nx--;
						endcase
						if (nx >= 0 && ny >= 0 && nx < grid_cols && nx < MAX_WIDTH &&
						    ny < grid_rows && ny < MAX_HEIGHT) begin
							if (!maze_wall[ny * MAX_WIDTH + nx]) begin
								walker_dir = h;
								walker_col = nx[COORD_W-1:0];
								walker_row = ny[COORD_W-1:0];
								if (walker_col == goal_col && walker_row == goal_row) begin
									walk_done = 1'b1;
									st = STAT_GOAL;
								end else begin
									st = STAT_MOVED;
								end
							end
						end
					end
				end
			end
			default: ;
		endcase
		o.walker_x       = walker_col;
		o.walker_y       = walker_row;
		o.walker_heading = walker_dir;
		o.status         = st;
		return o;
	endfunction

	function automatic req_t load_req(input int x, input int y, input bit wall);
		return '{REQ_LOAD, 6'(x), 6'(y), wall};
	endfunction

	// cell fields carry noise on requests that ignore them
	function automatic req_t plain_req(input logic [1:0] code);
		return '{code, 6'($urandom), 6'($urandom), 1'($urandom)};
	endfunction

	function automatic script_row_t fixed_row(input req_t r, input int x, input int y,
	                                          input logic [1:0] h, input logic [2:0] st);
		script_row_t row;
		row.kind  = ROW_ITEM;
		row.item  = r;
		row.fixed = 1'b1;
		row.want  = '{6'(x), 6'(y), h, st};
		return row;
	endfunction

	function automatic script_row_t model_row(input req_t r);
		script_row_t row;
		row.kind  = ROW_ITEM;
		row.item  = r;
		row.fixed = 1'b0;
		return row;
	endfunction

	function automatic script_row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input int val);
		script_row_t row;
		row.kind    = ROW_REG;
		row.reg_idx = idx;
		row.reg_val = 7'(val);
		return row;
	endfunction

	function automatic int pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return $urandom_range(1, 8);
		else if (r < 85)
			return $urandom_range(9, 64);
		else if (r < 92)
			return 64;
		else if (r < 96)
			return 0;
		return $urandom_range(65, 127);
	endfunction

	task automatic send_item(input req_t r, input bit fixed, input rsp_t want);
		int gap;
		last_outcome = predict_walk(r);
		walk_expect_q.push_back(fixed ? want : last_outcome);
		if (r.req_type == REQ_STEP)
			status_tally[last_outcome.status]++;
		item_count++;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = fast_sender ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic send(input req_t r);
		send_item(r, 1'b0, '0);
	endtask

	// registers change only with the walker idle and every result in
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		req_valid <= 1'b0;
		while (walk_expect_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			CFG_GRID_WIDTH:  grid_cols = val;
			CFG_GRID_HEIGHT: grid_rows = val;
			CFG_START_X:     start_col = val[COORD_W-1:0];
			CFG_START_Y:     start_row = val[COORD_W-1:0];
			CFG_END_X:       goal_col  = val[COORD_W-1:0];
			CFG_END_Y:       goal_row  = val[COORD_W-1:0];
			default: ;
		endcase
	endtask

	// receiver stall patterns
	initial begin : rsp_side
		stall_mode_t mode;
		int          left, run;
		bit          hold;
		left = 0;
		run  = 0;
		hold = 1'b0;
		mode = STALL_NONE;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				mode = stall_mode_t'($urandom_range(0, 3));
				left = $urandom_range(50, 300);
			end
			left--;
			case (mode)
				STALL_NONE:   rsp_stall <= 1'b0;
				STALL_RANDOM: rsp_stall <= ($urandom_range(0, 99) < 30);
				STALL_RUNS: begin
					if (run == 0) begin
						hold = !hold;
						run  = hold ? $urandom_range(1, 8) : $urandom_range(1, 12);
					end
					run--;
					rsp_stall <= hold;
				end
				STALL_TOGGLE: rsp_stall <= !rsp_stall;
			endcase
		end
	end

	// result checker
	always @(posedge clk) begin : rsp_check
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (walk_expect_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected result: x=%0d y=%0d h=%0d st=%0d",
					         rsp.walker_x, rsp.walker_y, rsp.walker_heading, rsp.status);
			end else begin
				want = walk_expect_q.pop_front();
				if (rsp.walker_x !== want.walker_x || rsp.walker_y !== want.walker_y ||
				    rsp.walker_heading !== want.walker_heading || rsp.status !== want.status) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("mismatch: want x=%0d y=%0d h=%0d st=%0d, got x=%0d y=%0d h=%0d st=%0d",
						         want.walker_x, want.walker_y, want.walker_heading, want.status,
						         rsp.walker_x, rsp.walker_y, rsp.walker_heading, rsp.status);
				end
			end
		end
	end

	// ends the run when no transaction moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("right_hand_wall_follower verification failed");
		$finish;
	end

	initial begin : main
		int  w, h, uw, uh, lw, lh, sx, sy, ex, ey, cap, n, k, rand_base;
		bit  stop;
		mismatches    = 0;
		item_count    = 0;
		setting_count = 1;
		burst_left    = 0;
		fast_sender   = 1'b0;
		foreach (status_tally[i]) status_tally[i] = 0;
		foreach (maze_wall[i]) maze_wall[i] = 1'b0;
		visited    = '0;
		grid_cols  = 64;
		grid_rows  = 64;
		start_col  = '0;
		start_row  = '0;
		goal_col   = 6'd63;
		goal_row   = 6'd63;
		walker_col = '0;
		walker_row = '0;
		walker_dir = HEAD_N;
		walk_done  = 1'b0;

		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		cfg_write <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// open corner block fenced by walls on its far row and column, so a
		// walker that starts inside never probes an unwritten cell
		for (int y = 0; y <= WALK_SPAN; y++)
			for (int x = 0; x <= WALK_SPAN; x++)
				send(load_req(x, y, (x == WALK_SPAN) || (y == WALK_SPAN)));

		// default settings: 64 x 64, start in the corner, goal in the far corner
		script.push_back(fixed_row(plain_req(REQ_RESTART), 0, 0, HEAD_N, STAT_ACCEPTED));
		script.push_back(fixed_row(plain_req(REQ_SPARE), 0, 0, HEAD_N, STAT_ACCEPTED));
		// open floor: the walker circles one block and meets its own trail
		script.push_back(fixed_row(plain_req(REQ_STEP), 1, 0, HEAD_E, STAT_MOVED));
		script.push_back(fixed_row(plain_req(REQ_STEP), 1, 1, HEAD_S, STAT_MOVED));
		script.push_back(fixed_row(plain_req(REQ_STEP), 0, 1, HEAD_W, STAT_MOVED));
		script.push_back(fixed_row(plain_req(REQ_STEP), 0, 0, HEAD_N, STAT_MOVED));
		script.push_back(fixed_row(plain_req(REQ_STEP), 0, 0, HEAD_N, STAT_LOOP));
		// boxed-in start, then the same position again counts as a loop
		script.push_back(fixed_row(load_req(63, 63, 1'b1), 0, 0, HEAD_N, STAT_ACCEPTED));
		script.push_back(fixed_row(load_req(1, 0, 1'b1), 0, 0, HEAD_N, STAT_ACCEPTED));
		script.push_back(fixed_row(load_req(0, 1, 1'b1), 0, 0, HEAD_N, STAT_ACCEPTED));
		script.push_back(fixed_row(plain_req(REQ_RESTART), 0, 0, HEAD_N, STAT_ACCEPTED));
		script.push_back(fixed_row(plain_req(REQ_STEP), 0, 0, HEAD_N, STAT_WALLED));
		script.push_back(fixed_row(plain_req(REQ_STEP), 0, 0, HEAD_N, STAT_LOOP));
		// only the way back is open
		script.push_back(model_row(load_req(0, 1, 1'b0)));
		script.push_back(model_row(plain_req(REQ_RESTART)));
		script.push_back(model_row(plain_req(REQ_STEP)));
		// goal one cell away, then finished until restart
		script.push_back(model_row(load_req(1, 0, 1'b0)));
		script.push_back(reg_row(CFG_END_X, 1));
		script.push_back(reg_row(CFG_END_Y, 0));
		script.push_back(model_row(plain_req(REQ_RESTART)));
		script.push_back(fixed_row(plain_req(REQ_STEP), 1, 0, HEAD_E, STAT_GOAL));
		script.push_back(fixed_row(plain_req(REQ_STEP), 1, 0, HEAD_E, STAT_FINISHED));
		// goal on the start cell
		script.push_back(reg_row(CFG_END_X, 0));
		script.push_back(fixed_row(plain_req(REQ_RESTART), 0, 0, HEAD_N, STAT_ACCEPTED));
		script.push_back(fixed_row(plain_req(REQ_STEP), 0, 0, HEAD_N, STAT_GOAL));
		script.push_back(fixed_row(plain_req(REQ_STEP), 0, 0, HEAD_N, STAT_FINISHED));
		// zero columns: nowhere to go
		script.push_back(reg_row(CFG_END_X, 63));
		script.push_back(reg_row(CFG_END_Y, 63));
		script.push_back(reg_row(CFG_GRID_WIDTH, 0));
		script.push_back(fixed_row(plain_req(REQ_RESTART), 0, 0, HEAD_N, STAT_ACCEPTED));
		script.push_back(fixed_row(plain_req(REQ_STEP), 0, 0, HEAD_N, STAT_WALLED));
		// oversized grid is clipped at the store edge
		script.push_back(model_row(load_req(63, 62, 1'b0)));
		script.push_back(reg_row(CFG_GRID_WIDTH, 127));
		script.push_back(reg_row(CFG_GRID_HEIGHT, 127));
		script.push_back(reg_row(CFG_START_X, 63));
		script.push_back(reg_row(CFG_START_Y, 63));
		script.push_back(reg_row(CFG_END_X, 0));
		script.push_back(reg_row(CFG_END_Y, 0));
		script.push_back(reg_row(CFG_SPARE, 127));
		script.push_back(fixed_row(plain_req(REQ_RESTART), 63, 63, HEAD_N, STAT_ACCEPTED));
		script.push_back(fixed_row(plain_req(REQ_STEP), 63, 62, HEAD_N, STAT_MOVED));
		// single row grid with the walker off it
		script.push_back(reg_row(CFG_GRID_WIDTH, 64));
		script.push_back(reg_row(CFG_GRID_HEIGHT, 1));
		script.push_back(model_row(plain_req(REQ_RESTART)));
		script.push_back(fixed_row(plain_req(REQ_STEP), 63, 63, HEAD_N, STAT_WALLED));

		foreach (script[i]) begin
			if (script[i].kind == ROW_REG) begin
				write_reg(script[i].reg_idx, script[i].reg_val);
				setting_count++;
			end else begin
				send_item(script[i].item, script[i].fixed, script[i].want);
			end
		end

		// random mazes: load the grid, restart, walk until it resolves
		rand_base = item_count;
		while (item_count - rand_base < RANDOM_ITEMS) begin
			w  = pick_size();
			h  = pick_size();
			uw = (w > MAX_WIDTH) ? MAX_WIDTH : w;
			uh = (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
			lw = (uw > WALK_SPAN) ? WALK_SPAN : uw;
			lh = (uh > WALK_SPAN) ? WALK_SPAN : uh;
			// a wide axis keeps the start inside the fenced block
			if (uw > WALK_SPAN)
				sx = $urandom_range(0, WALK_SPAN - 1);
			else
				sx = (uw > 0 && $urandom_range(0, 99) < 85) ? $urandom_range(0, uw - 1) :
				                                                $urandom_range(0, 63);
			if (uh > WALK_SPAN)
				sy = $urandom_range(0, WALK_SPAN - 1);
			else
				sy = (uh > 0 && $urandom_range(0, 99) < 85) ? $urandom_range(0, uh - 1) :
				                                                $urandom_range(0, 63);
			ex = (uw > 0 && $urandom_range(0, 99) < 85) ? $urandom_range(0, uw - 1) :
			                                                $urandom_range(0, 63);
			ey = (uh > 0 && $urandom_range(0, 99) < 85) ? $urandom_range(0, uh - 1) :
			                                                $urandom_range(0, 63);
			// top data bit is noise on the six-bit registers
			write_reg(CFG_GRID_WIDTH, 7'(w));
			write_reg(CFG_GRID_HEIGHT, 7'(h));
			write_reg(CFG_START_X, {1'($urandom), 6'(sx)});
			write_reg(CFG_START_Y, {1'($urandom), 6'(sy)});
			write_reg(CFG_END_X, {1'($urandom), 6'(ex)});
			write_reg(CFG_END_Y, {1'($urandom), 6'(ey)});
			setting_count++;
			fast_sender = ($urandom_range(0, 3) == 0);

			if (lw * lh <= 64) begin
				for (int y = 0; y < lh; y++)
					for (int x = 0; x < lw; x++)
						send(load_req(x, y, $urandom_range(0, 9) < 3));
			end else begin
				repeat (40)
					send(load_req($urandom_range(0, lw - 1), $urandom_range(0, lh - 1),
					              $urandom_range(0, 9) < 3));
			end
			send(plain_req(REQ_RESTART));

			cap = uw * uh * 4 + 8;
			if (cap > 200)
				cap = 200;
			stop = 1'b0;
			n    = 0;
			while (!stop && n < cap) begin
				k = $urandom_range(0, 99);
				if (k < 4) begin
					send(load_req($urandom_range(0, WALK_SPAN - 1),
					              $urandom_range(0, WALK_SPAN - 1), 1'($urandom)));
				end else if (k < 6) begin
					send(plain_req(REQ_SPARE));
				end else if (k < 8) begin
					send(plain_req(REQ_RESTART));
				end else begin
					send(plain_req(REQ_STEP));
					if (last_outcome.status == STAT_GOAL || last_outcome.status == STAT_LOOP ||
					    last_outcome.status == STAT_WALLED)
						stop = 1'b1;
				end
				n++;
			end
			// steps after the walk has resolved
			repeat ($urandom_range(1, 2))
				send(plain_req(REQ_STEP));
		end

		req_valid <= 1'b0;
		while (walk_expect_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d transactions over %0d grid settings, random mazes with burst and stall idling",
		         item_count, setting_count);
		$display("steps: %0d moved, %0d goal, %0d loop, %0d walled in, %0d already finished",
		         status_tally[STAT_MOVED], status_tally[STAT_GOAL], status_tally[STAT_LOOP],
		         status_tally[STAT_WALLED], status_tally[STAT_FINISHED]);
		if (mismatches == 0 && walk_expect_q.size() == 0) begin
			$display("right_hand_wall_follower verification clean");
		end else begin
			$display("right_hand_wall_follower verification failed");
		end
		$finish;
	end

endmodule
